@@ rtl/first_order_image_sources_defines.svh @@
// assertion macros for the first-order image source block
`ifndef FIRST_ORDER_IMAGE_SOURCES_DEFINES_SVH
`define FIRST_ORDER_IMAGE_SOURCES_DEFINES_SVH

`ifndef SYNTHESIS
`define FO_IMG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define FO_IMG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FO_IMG_ASSERT_IMP(label, ante, cons, msg)
`define FO_IMG_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/fo_img_pkg.sv @@
// shared types and constants of the first-order image source block
package fo_img_pkg;

    localparam int SRC_W      = 18;
    localparam int IMG_W      = 19;
    localparam int DIM_W      = 16;
    localparam int ABS_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int RAD_W      = 32;
    localparam int REM_W      = 17;
    localparam int RDC_W      = 15;
    localparam int SQRT_STEPS = 16;
    localparam int NUM_FACES  = 6;
    localparam int NUM_BANDS  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 112;
    localparam int M_USER_W   = 4;

    localparam logic [RDC_W-1:0] ONE_Q14 = 15'd16384;

    localparam logic [2:0] FACE_NEG_X = 3'd0;
    localparam logic [2:0] FACE_POS_Z = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOM_VALID   = 3'd0,
        REG_ROOM_SIZE    = 3'd1,
        REG_ABSORB_NEG_X = 3'd2,
        REG_ABSORB_POS_X = 3'd3,
        REG_ABSORB_NEG_Y = 3'd4,
        REG_ABSORB_POS_Y = 3'd5,
        REG_ABSORB_NEG_Z = 3'd6,
        REG_ABSORB_POS_Z = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic             image_valid;
        logic [2:0]       face_index;
        logic [IMG_W-1:0] image_x;
        logic [IMG_W-1:0] image_y;
        logic [IMG_W-1:0] image_z;
        logic             last_image;
    } item_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [GAIN_W-1:0] root;
    } band_t;

    typedef struct packed {
        logic                      valid;
        item_t                     item;
        band_t [NUM_BANDS-1:0]     band;
    } stage_t;

endpackage

@@ rtl/first_order_image_sources.sv @@
// top level of the first-order image source block: sequencer and square root cell chain
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: source x, y, z
//  m_       out  m_tvalid/m_tready    m_tdata: image x, y, z, gains; m_tuser; m_tlast
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one result per cycle while m_ is not stalled: a source in the room gives six results, a rejected one a single result
//  each issued face leaves after passing through the 16 registered square root cells
//  a stalled m_ side holds the whole cell chain; the sequencer still takes a source when idle
//  reset clears the configuration registers to zero and empties the chain
`include "first_order_image_sources_defines.svh"

module first_order_image_sources (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fo_img_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fo_img_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // source_x, source_y, source_z, zero pad
    input  logic [fo_img_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // image_x, image_y, image_z, gain_band_low, gain_band_mid, gain_band_high, zero pad
    output logic [fo_img_pkg::M_DATA_W-1:0]     m_tdata,
    // image_valid, face_index
    output logic [fo_img_pkg::M_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    fo_img_pkg::stage_t chain [fo_img_pkg::SQRT_STEPS+1];
    fo_img_pkg::stage_t tail;
    logic               advance;

    assign tail    = chain[fo_img_pkg::SQRT_STEPS];
    assign advance = !tail.valid || m_tready;

    fo_img_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .advance   (advance),
        .issue     (chain[0])
    );

    for (genvar i = 0; i < fo_img_pkg::SQRT_STEPS; i++) begin : g_cell
        fo_img_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_stage  (chain[i]),
            .out_stage (chain[i+1])
        );
    end

    assign m_tvalid = tail.valid;
    assign m_tlast  = tail.item.last_image;
    assign m_tuser  = {tail.item.face_index, tail.item.image_valid};
    assign m_tdata  = {7'b0,
                       tail.band[2].root,
                       tail.band[1].root,
                       tail.band[0].root,
                       tail.item.image_z,
                       tail.item.image_y,
                       tail.item.image_x};

    `FO_IMG_ASSERT_IMP(a_only_last_invalid, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == '0) && (m_tuser == '0), "invalid result must be a single all-zero final transfer")
    `FO_IMG_ASSERT_IMP(a_gain_range, m_tvalid, (m_tdata[72:57] <= 16'd32768) && (m_tdata[88:73] <= 16'd32768) && (m_tdata[104:89] <= 16'd32768), "gain above one")
    `FO_IMG_ASSERT_IMP(a_last_on_pos_z, m_tvalid && m_tuser[0] && m_tlast, m_tuser[3:1] == fo_img_pkg::FACE_POS_Z, "final image not on the +z face")

endmodule

@@ rtl/fo_img_seq.sv @@
// configuration registers, room check and face sequencer feeding the cell chain
`include "first_order_image_sources_defines.svh"

module fo_img_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fo_img_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fo_img_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fo_img_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                                advance,
    output fo_img_pkg::stage_t                  issue
);

    logic                                 room_valid_reg;
    logic [fo_img_pkg::CFG_DATA_W-1:0]    room_size_reg;
    logic [fo_img_pkg::CFG_DATA_W-1:0]    absorb_reg [fo_img_pkg::NUM_FACES];

    logic                                 busy_reg, busy_next;
    logic                                 ok_reg, ok_next;
    logic [2:0]                           face_reg, face_next;
    logic [3*fo_img_pkg::SRC_W-1:0]       src_reg, src_next;

    logic signed [19:0] s2_in [3];
    logic signed [19:0] lo2   [3];
    logic signed [19:0] hi2   [3];
    logic [fo_img_pkg::DIM_W-1:0] dim [3];
    logic               ok_in;
    logic               last_face;

    logic signed [19:0] src_ext [3];
    logic signed [19:0] plane2;
    logic signed [19:0] mirrored;
    logic [1:0]         axis;
    logic [fo_img_pkg::CFG_DATA_W-1:0] absorb_sel;
    logic signed [fo_img_pkg::ABS_W-1:0] absorb_band [fo_img_pkg::NUM_BANDS];
    logic [fo_img_pkg::RDC_W-1:0] radicand [fo_img_pkg::NUM_BANDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_valid_reg <= 1'b0;
            room_size_reg  <= '0;
            for (int i = 0; i < fo_img_pkg::NUM_FACES; i++) begin
                absorb_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (fo_img_pkg::cfg_reg_t'(cfg_index))
                fo_img_pkg::REG_ROOM_VALID:   room_valid_reg <= cfg_data[0];
                fo_img_pkg::REG_ROOM_SIZE:    room_size_reg  <= cfg_data;
                fo_img_pkg::REG_ABSORB_NEG_X: absorb_reg[0]  <= cfg_data;
                fo_img_pkg::REG_ABSORB_POS_X: absorb_reg[1]  <= cfg_data;
                fo_img_pkg::REG_ABSORB_NEG_Y: absorb_reg[2]  <= cfg_data;
                fo_img_pkg::REG_ABSORB_POS_Y: absorb_reg[3]  <= cfg_data;
                fo_img_pkg::REG_ABSORB_NEG_Z: absorb_reg[4]  <= cfg_data;
                fo_img_pkg::REG_ABSORB_POS_Z: absorb_reg[5]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // doubled plane positions and the inside-the-room check on the incoming source
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dim[a]   = room_size_reg[a*fo_img_pkg::DIM_W +: fo_img_pkg::DIM_W];
            s2_in[a] = {s_tdata[a*fo_img_pkg::SRC_W + fo_img_pkg::SRC_W - 1],
                        s_tdata[a*fo_img_pkg::SRC_W +: fo_img_pkg::SRC_W], 1'b0};
        end
        lo2[0] = 20'sd0 - $signed({4'b0, dim[0]});
        hi2[0] = $signed({4'b0, dim[0]});
        lo2[1] = 20'sd0;
        hi2[1] = $signed({3'b0, dim[1], 1'b0});
        lo2[2] = 20'sd0 - $signed({4'b0, dim[2]});
        hi2[2] = $signed({4'b0, dim[2]});
        ok_in = room_valid_reg && (dim[0] != '0) && (dim[1] != '0) && (dim[2] != '0);
        for (int a = 0; a < 3; a++) begin
            if ((s2_in[a] < lo2[a]) || (s2_in[a] > hi2[a])) begin
                ok_in = 1'b0;
            end
        end
    end

    assign last_face = !ok_reg || (face_reg == fo_img_pkg::FACE_POS_Z);
    assign s_tready  = !busy_reg || (advance && last_face);

    always_comb begin
        busy_next = busy_reg;
        ok_next   = ok_reg;
        face_next = face_reg;
        src_next  = src_reg;
        if (busy_reg && advance) begin
            if (last_face) begin
                busy_next = 1'b0;
            end else begin
                face_next = face_reg + 3'd1;
            end
        end
        if (s_tvalid && s_tready) begin
            busy_next = 1'b1;
            ok_next   = ok_in;
            face_next = fo_img_pkg::FACE_NEG_X;
            src_next  = s_tdata[3*fo_img_pkg::SRC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ok_reg   <= 1'b0;
            face_reg <= fo_img_pkg::FACE_NEG_X;
        end else begin
            busy_reg <= busy_next;
            ok_reg   <= ok_next;
            face_reg <= face_next;
        end
        src_reg <= src_next;
    end

    // mirrored coordinate of the current face
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            src_ext[a] = 20'(signed'(src_reg[a*fo_img_pkg::SRC_W +: fo_img_pkg::SRC_W]));
        end
        axis = face_reg[2:1];
        case (axis)
            2'd0:    plane2 = face_reg[0] ? $signed({4'b0, room_size_reg[15:0]})
                                          : 20'sd0 - $signed({4'b0, room_size_reg[15:0]});
            2'd1:    plane2 = face_reg[0] ? $signed({3'b0, room_size_reg[31:16], 1'b0})
                                          : 20'sd0;
            2'd2:    plane2 = face_reg[0] ? $signed({4'b0, room_size_reg[47:32]})
                                          : 20'sd0 - $signed({4'b0, room_size_reg[47:32]});
            default: plane2 = 20'sd0;
        endcase
        mirrored = plane2 - src_ext[axis];
    end

    // clamped absorption turned into the square root radicand
    always_comb begin
        absorb_sel = (face_reg < 3'(fo_img_pkg::NUM_FACES)) ? absorb_reg[face_reg] : '0;
        for (int b = 0; b < fo_img_pkg::NUM_BANDS; b++) begin
            absorb_band[b] = signed'(absorb_sel[b*fo_img_pkg::ABS_W +: fo_img_pkg::ABS_W]);
            if (absorb_band[b][fo_img_pkg::ABS_W-1]) begin
                radicand[b] = fo_img_pkg::ONE_Q14;
            end else if (absorb_band[b] > $signed({1'b0, fo_img_pkg::ONE_Q14})) begin
                radicand[b] = '0;
            end else begin
                radicand[b] = fo_img_pkg::ONE_Q14 - absorb_band[b][fo_img_pkg::RDC_W-1:0];
            end
        end
    end

    always_comb begin
        issue       = '0;
        issue.valid = busy_reg;
        if (ok_reg) begin
            issue.item.image_valid = 1'b1;
            issue.item.face_index  = face_reg;
            issue.item.image_x     = src_ext[0][fo_img_pkg::IMG_W-1:0];
            issue.item.image_y     = src_ext[1][fo_img_pkg::IMG_W-1:0];
            issue.item.image_z     = src_ext[2][fo_img_pkg::IMG_W-1:0];
            case (axis)
                2'd0:    issue.item.image_x = mirrored[fo_img_pkg::IMG_W-1:0];
                2'd1:    issue.item.image_y = mirrored[fo_img_pkg::IMG_W-1:0];
                default: issue.item.image_z = mirrored[fo_img_pkg::IMG_W-1:0];
            endcase
            for (int b = 0; b < fo_img_pkg::NUM_BANDS; b++) begin
                issue.band[b].rad = {1'b0, radicand[b], 16'b0};
            end
        end
        issue.item.last_image = last_face;
    end

    `FO_IMG_ASSERT_NXT(a_bad_source_single, s_tvalid && s_tready && !ok_in, issue.valid && issue.item.last_image && !issue.item.image_valid, "rejected source must give one final invalid result")
    `FO_IMG_ASSERT_IMP(a_face_range, busy_reg, face_reg <= fo_img_pkg::FACE_POS_Z, "face counter out of range")
    `FO_IMG_ASSERT_IMP(a_hold_when_stalled, busy_reg && !advance, !s_tready, "source taken while faces remain stalled")

endmodule

@@ rtl/fo_img_cell.sv @@
// one square root digit cell: retires one root bit per band and passes the item on
module fo_img_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  fo_img_pkg::stage_t in_stage,
    output fo_img_pkg::stage_t out_stage
);

    fo_img_pkg::stage_t stage_reg, stage_next;

    logic [fo_img_pkg::REM_W+1:0] rem_sh [fo_img_pkg::NUM_BANDS];
    logic [fo_img_pkg::REM_W+1:0] trial  [fo_img_pkg::NUM_BANDS];

    always_comb begin
        stage_next = in_stage;
        for (int b = 0; b < fo_img_pkg::NUM_BANDS; b++) begin
            rem_sh[b] = {in_stage.band[b].rem, in_stage.band[b].rad[fo_img_pkg::RAD_W-1 -: 2]};
            trial[b]  = {1'b0, in_stage.band[b].root, 2'b01};
            stage_next.band[b].rad = {in_stage.band[b].rad[fo_img_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh[b] >= trial[b]) begin
                stage_next.band[b].rem  = fo_img_pkg::REM_W'(rem_sh[b] - trial[b]);
                stage_next.band[b].root = {in_stage.band[b].root[fo_img_pkg::GAIN_W-2:0], 1'b1};
            end else begin
                stage_next.band[b].rem  = rem_sh[b][fo_img_pkg::REM_W-1:0];
                stage_next.band[b].root = {in_stage.band[b].root[fo_img_pkg::GAIN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule
